// File: design/tabbt_pkg.sv
// Shared types, constants and helpers for the triangular matrix-product block.
package tabbt_pkg;

  // Largest matrix dimension the stores are built for.
  localparam int MAX_DIM  = 8;
  localparam int NUM_ELEM = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = $clog2(NUM_ELEM);

  // Fixed field widths.
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 16;
  localparam int SIZE_W      = 4;
  localparam int PP_W        = 35;
  localparam int MUL_W       = 51;
  localparam int RES_W       = 56;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Operation carried by one multiply-accumulate beat.
  typedef enum logic [1:0] {
    OP_AB   = 2'd0,
    OP_ABBT = 2'd1,
    OP_ATA  = 2'd2
  } op_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_AB   = 6'b000010,
    ST_WAIT = 6'b000100,
    ST_ABBT = 6'b001000,
    ST_ATA  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  // Tags that travel with one multiply-accumulate beat down the pipeline.
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             first;
    logic             last;
    logic             last_flag;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } mac_tag_t;

  // Row-major address of element (r, c).
  function automatic logic [ADDR_W-1:0] elem_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

// File: design/triangular_abbt_plus_ata.sv
// Top level of the triangular matrix-product block C = A*B*B^T + A^T*A.
//
// Input stream: each beat carries a request kind on s_axis_tuser. Kinds 0 and 1
// load one Q8.8 element of A or B at (row, col); loads with an index at or
// above the built dimension are dropped. Kind 2 computes C over the
// leading N x N part, N being size_in_use clamped to 1..MAX_DIM, with A taken as
// upper triangular. Every used element must be loaded before a compute.
// Output stream: N*N beats of C, row by row, 24 fraction bits, tlast on the last.
// A single multiplier issues one multiply-accumulate per cycle while a sum is
// walked, through a three-stage pipeline (RAM read, multiply, accumulate). A
// compute first walks A*B into the partial store, then for each element of C
// passes a wait state, the A*B*B^T sum over all N terms and the A^T*A sum up
// to k = min(i,j). s_axis_tready is low for the whole compute.
// Each result waits in an output register; the next element starts only after
// that register has been taken, so a stalled receiver stalls the sequencer.
// Reset (rst, synchronous) empties the pipeline and the output register and
// sets size_in_use to 8; matrix contents are undefined until loaded.
module triangular_abbt_plus_ata (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tabbt_pkg::SIZE_W-1:0]        cfg_wr_data,    // size_in_use
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] row, [5:3] col, [21:6] element_value, [23:22] zero
  input  logic [tabbt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,   // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [61:6] result_value, [63:62] zero
  output logic [tabbt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast    // last_flag
);

  localparam int AW = tabbt_pkg::ADDR_W;
  localparam int XW = tabbt_pkg::IDX_W;

  // Configuration and sequencer registers.
  logic [tabbt_pkg::SIZE_W-1:0] size_in_use;
  tabbt_pkg::state_t            state, state_next;
  logic [XW-1:0]                i, i_next, j, j_next, k, k_next, n_m1, n_m1_next;

  // Input beat fields.
  logic                         in_acc;
  logic [XW-1:0]                in_row, in_col;
  logic [tabbt_pkg::VAL_W-1:0]  in_val;
  logic                         in_idx_ok;

  // Issue stage and pipeline tags.
  tabbt_pkg::mac_tag_t          iss, s1, s2;
  logic [XW-1:0]                lim;
  logic [tabbt_pkg::SIZE_W-1:0] dim;
  logic                         pipe_idle;

  // Memory ports.
  logic [AW-1:0]                a0_raddr, a1_raddr, b_raddr, p_raddr, p_waddr, ld_addr;
  logic                         a_we, b_we, p_we;
  logic [tabbt_pkg::VAL_W-1:0]  a0_q, a1_q, b_q;
  logic [tabbt_pkg::PP_W-1:0]   p_q;

  // Datapath.
  logic signed [tabbt_pkg::PP_W-1:0]  mul_a;
  logic signed [tabbt_pkg::VAL_W-1:0] mul_b;
  logic signed [tabbt_pkg::MUL_W-1:0] mul_p, s2_prod;
  logic signed [tabbt_pkg::RES_W-1:0] prod_ext, acc, acc_sum;

  // Output register.
  logic [XW-1:0]                out_row, out_col;
  logic [tabbt_pkg::RES_W-1:0]  out_value;
  logic                         out_last;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_row    = s_axis_tdata[2:0];
  assign in_col    = s_axis_tdata[5:3];
  assign in_val    = s_axis_tdata[21:6];
  assign in_idx_ok = ({1'b0, in_row} < 4'(tabbt_pkg::MAX_DIM)) &&
                     ({1'b0, in_col} < 4'(tabbt_pkg::MAX_DIM));
  assign s_axis_tready = (state == tabbt_pkg::ST_IDLE);
  assign pipe_idle     = !s1.valid && !s2.valid;
  assign lim           = (i < j) ? i : j;

  // Clamp the configured size to the built range.
  always_comb begin
    if (size_in_use == '0) begin
      dim = tabbt_pkg::SIZE_W'(1);
    end else if (size_in_use > tabbt_pkg::SIZE_W'(tabbt_pkg::MAX_DIM)) begin
      dim = tabbt_pkg::SIZE_W'(tabbt_pkg::MAX_DIM);
    end else begin
      dim = size_in_use;
    end
  end

  // Sequencer: walks A*B, then for each element of C the A*B*B^T and A^T*A sums.
  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    n_m1_next     = n_m1;
    iss           = '0;
    iss.op        = tabbt_pkg::OP_AB;
    iss.i         = i;
    iss.j         = j;
    iss.last_flag = (i == n_m1) && (j == n_m1);
    case (state)
      tabbt_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tuser == tabbt_pkg::REQ_COMPUTE) begin
          n_m1_next  = XW'(dim - tabbt_pkg::SIZE_W'(1));
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = tabbt_pkg::ST_AB;
        end
      end
      tabbt_pkg::ST_AB: begin
        iss.valid = 1'b1;
        iss.op    = tabbt_pkg::OP_AB;
        iss.first = (k == i);
        iss.last  = (k == n_m1);
        if (k == n_m1) begin
          if (j == n_m1) begin
            j_next = '0;
            if (i == n_m1) begin
              i_next     = '0;
              k_next     = '0;
              state_next = tabbt_pkg::ST_WAIT;
            end else begin
              i_next = i + XW'(1);
              k_next = i + XW'(1);
            end
          end else begin
            j_next = j + XW'(1);
            k_next = i;
          end
        end else begin
          k_next = k + XW'(1);
        end
      end
      tabbt_pkg::ST_WAIT: begin
        if (pipe_idle && !m_axis_tvalid) begin
          k_next     = '0;
          state_next = tabbt_pkg::ST_ABBT;
        end
      end
      tabbt_pkg::ST_ABBT: begin
        iss.valid = 1'b1;
        iss.op    = tabbt_pkg::OP_ABBT;
        iss.first = (k == '0);
        if (k == n_m1) begin
          k_next     = '0;
          state_next = tabbt_pkg::ST_ATA;
        end else begin
          k_next = k + XW'(1);
        end
      end
      tabbt_pkg::ST_ATA: begin
        iss.valid = 1'b1;
        iss.op    = tabbt_pkg::OP_ATA;
        iss.last  = (k == lim);
        if (k == lim) begin
          k_next = '0;
          if ((i == n_m1) && (j == n_m1)) begin
            state_next = tabbt_pkg::ST_FIN;
          end else begin
            state_next = tabbt_pkg::ST_WAIT;
            if (j == n_m1) begin
              j_next = '0;
              i_next = i + XW'(1);
            end else begin
              j_next = j + XW'(1);
            end
          end
        end else begin
          k_next = k + XW'(1);
        end
      end
      tabbt_pkg::ST_FIN: begin
        if (pipe_idle) begin
          state_next = tabbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tabbt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tabbt_pkg::ST_IDLE;
      size_in_use <= tabbt_pkg::SIZE_W'(8);
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        size_in_use <= cfg_wr_data;
      end
    end
  end

  // Counters and pipeline tags; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1.valid <= iss.valid;
      s2.valid <= s1.valid;
    end
    i              <= i_next;
    j              <= j_next;
    k              <= k_next;
    n_m1           <= n_m1_next;
    s1.op          <= iss.op;
    s1.first       <= iss.first;
    s1.last        <= iss.last;
    s1.last_flag   <= iss.last_flag;
    s1.i           <= iss.i;
    s1.j           <= iss.j;
    s2.op          <= s1.op;
    s2.first       <= s1.first;
    s2.last        <= s1.last;
    s2.last_flag   <= s1.last_flag;
    s2.i           <= s1.i;
    s2.j           <= s1.j;
    s2_prod        <= mul_p;
  end

  // Read addresses for the beat being issued.
  always_comb begin
    a0_raddr = tabbt_pkg::elem_addr(k, i);
    b_raddr  = tabbt_pkg::elem_addr(j, k);
    if (iss.op == tabbt_pkg::OP_AB) begin
      a0_raddr = tabbt_pkg::elem_addr(i, k);
      b_raddr  = tabbt_pkg::elem_addr(k, j);
    end
  end
  assign a1_raddr = tabbt_pkg::elem_addr(k, j);
  assign p_raddr  = tabbt_pkg::elem_addr(i, k);

  // Write ports: loads for A and B, elements of A*B for the partial store.
  assign ld_addr = tabbt_pkg::elem_addr(in_row, in_col);
  assign a_we    = in_acc && in_idx_ok && (s_axis_tuser == tabbt_pkg::REQ_LOAD_A);
  assign b_we    = in_acc && in_idx_ok && (s_axis_tuser == tabbt_pkg::REQ_LOAD_B);
  assign p_we    = s2.valid && s2.last && (s2.op == tabbt_pkg::OP_AB);
  assign p_waddr = tabbt_pkg::elem_addr(s2.i, s2.j);

  // Two copies of A so that A^T*A reads an element of column i and of column j in the same cycle.
  tabbt_ram #(.WIDTH(tabbt_pkg::VAL_W), .DEPTH(tabbt_pkg::NUM_ELEM)) u_a0_ram (
    .clk(clk), .we(a_we), .waddr(ld_addr), .wdata(in_val), .raddr(a0_raddr), .rdata(a0_q)
  );
  tabbt_ram #(.WIDTH(tabbt_pkg::VAL_W), .DEPTH(tabbt_pkg::NUM_ELEM)) u_a1_ram (
    .clk(clk), .we(a_we), .waddr(ld_addr), .wdata(in_val), .raddr(a1_raddr), .rdata(a1_q)
  );
  tabbt_ram #(.WIDTH(tabbt_pkg::VAL_W), .DEPTH(tabbt_pkg::NUM_ELEM)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(ld_addr), .wdata(in_val), .raddr(b_raddr), .rdata(b_q)
  );
  tabbt_ram #(.WIDTH(tabbt_pkg::PP_W), .DEPTH(tabbt_pkg::NUM_ELEM)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(acc_sum[tabbt_pkg::PP_W-1:0]),
    .raddr(p_raddr), .rdata(p_q)
  );

  // Shared multiplier: operands chosen by the beat's operation.
  always_comb begin
    mul_a = tabbt_pkg::PP_W'($signed(a0_q));
    mul_b = $signed(b_q);
    if (s1.op == tabbt_pkg::OP_ABBT) begin
      mul_a = $signed(p_q);
    end
    if (s1.op == tabbt_pkg::OP_ATA) begin
      mul_b = $signed(a1_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Accumulator: A^T*A terms are scaled from 16 to 24 fraction bits.
  assign prod_ext = (s2.op == tabbt_pkg::OP_ATA) ? (tabbt_pkg::RES_W'(s2_prod) <<< 8)
                                                 : tabbt_pkg::RES_W'(s2_prod);
  assign acc_sum  = (s2.first ? '0 : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc <= acc_sum;
    end
  end

  // Output register: loaded only when empty, since each element waits for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s2.valid && s2.last && (s2.op == tabbt_pkg::OP_ATA)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.last && (s2.op == tabbt_pkg::OP_ATA)) begin
      out_row   <= s2.i;
      out_col   <= s2.j;
      out_value <= acc_sum;
      out_last  <= s2.last_flag;
    end
  end

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};
  assign m_axis_tlast = out_last;

endmodule

// File: design/tabbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tabbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
